// ===== design/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg: shared types, codes and helpers for the complex arithmetic unit
// Q-format constants, operation codes, pipeline payload types, saturating
// pack and the per-stage divide and square-root steps.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;          // field width
  localparam int PW        = 2 * DW;      // product width
  localparam int QW        = DW + 1;      // quotient / root bits kept
  localparam int NSTEP     = QW;          // one quotient bit per stage
  localparam int SQ_W      = 2 * QW;      // square-root remainder width
  // edges from a start transfer to the transfer of its result
  localparam int CAU_LATENCY = NSTEP + 6;

  // operation codes on in_func
  localparam logic [3:0] FN_ADD  = 4'd0;
  localparam logic [3:0] FN_SUB  = 4'd1;
  localparam logic [3:0] FN_MUL  = 4'd2;
  localparam logic [3:0] FN_DIV  = 4'd3;
  localparam logic [3:0] FN_SADD = 4'd4;
  localparam logic [3:0] FN_SSUB = 4'd5;
  localparam logic [3:0] FN_SMUL = 4'd6;
  localparam logic [3:0] FN_SDIV = 4'd7;
  localparam logic [3:0] FN_MOD  = 4'd8;

  // operation classes after decode
  localparam logic [2:0] K_NONE   = 3'd0;
  localparam logic [2:0] K_ADDSUB = 3'd1;
  localparam logic [2:0] K_MUL    = 3'd2;
  localparam logic [2:0] K_DIV    = 3'd3;
  localparam logic [2:0] K_MOD    = 3'd4;

  localparam logic [PW-1:0] NEG_MAG = PW'(1) << (DW - 1);
  localparam logic [PW-1:0] POS_MAG = NEG_MAG - PW'(1);
  localparam logic [PW-1:0] TOP_VAL = PW'(1) << (PW - 1);

  typedef struct packed {
    logic [2:0]    kind;
    logic          sub;
    logic          scal;
    logic [DW-1:0] a_re;
    logic [DW-1:0] a_im;
    logic [DW-1:0] b_re;
    logic [DW-1:0] b_im;
  } item_t;

  typedef struct packed {
    logic          sat;
    logic [DW-1:0] val;
  } packed_t;

  typedef struct packed {
    logic          neg;
    logic [PW-1:0] mag;
  } sm_t;

  // divider lane: partial remainder, quotient so far, dividend bits left
  typedef struct packed {
    logic          neg;
    logic          ovf;
    logic [PW-1:0] rem;
    logic [QW-1:0] quo;
    logic [QW-1:0] nlo;
  } dlane_t;

  // square-root lane: n minus root squared, root so far
  typedef struct packed {
    logic [SQ_W-1:0] rn;
    logic [QW-1:0]   rt;
  } sq_t;

  // control and finished simple results that ride along the divider
  typedef struct packed {
    logic [2:0]    kind;
    logic          dz;
    logic          sat;
    logic [DW-1:0] re;
    logic [DW-1:0] im;
  } ctl_t;

  // sign and magnitude into a saturated two's complement field
  function automatic packed_t sat_pack(input logic neg, input logic [PW-1:0] mag);
    packed_t p;
    p.sat = 1'b0;
    if (neg) begin
      if (mag > NEG_MAG) begin
        p.sat = 1'b1;
        p.val = NEG_MAG[DW-1:0];
      end else begin
        p.val = ~mag[DW-1:0] + DW'(1);
      end
    end else begin
      if (mag > POS_MAG) begin
        p.sat = 1'b1;
        p.val = POS_MAG[DW-1:0];
      end else begin
        p.val = mag[DW-1:0];
      end
    end
    return p;
  endfunction

  // wrapped sum whose true value lies in (-2^63, 2^63]
  function automatic sm_t split_wrap(input logic [PW-1:0] u);
    sm_t s;
    if (u == TOP_VAL) begin
      s.neg = 1'b0;
      s.mag = u;
    end else begin
      s.neg = u[PW-1];
      s.mag = u[PW-1] ? (~u + PW'(1)) : u;
    end
    return s;
  endfunction

  // one restoring division step: bring in the next dividend bit
  function automatic dlane_t div_step(input dlane_t l, input logic [PW-1:0] den);
    dlane_t         o;
    logic [PW:0]    r2;
    logic [PW:0]    dx;
    o  = l;
    r2 = {l.rem, l.nlo[QW-1]};
    dx = {1'b0, den};
    if (r2 >= dx) begin
      o.rem = PW'(r2 - dx);
      o.quo = {l.quo[QW-2:0], 1'b1};
    end else begin
      o.rem = r2[PW-1:0];
      o.quo = {l.quo[QW-2:0], 1'b0};
    end
    o.nlo = {l.nlo[QW-2:0], 1'b0};
    return o;
  endfunction

  // one square-root step deciding root bit i
  function automatic sq_t sq_step(input sq_t s, input int i);
    sq_t             o;
    logic [SQ_W-1:0] trial;
    o     = s;
    trial = (SQ_W'(s.rt) << (i + 1)) | (SQ_W'(1) << (2 * i));
    if (s.rn >= trial) begin
      o.rn = s.rn - trial;
      o.rt = s.rt | (QW'(1) << i);
    end
    return o;
  endfunction

endpackage

// ===== design/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front: command intake and decode
// Takes a start transfer when the queue has room and sorts the operation
// code into an operation class for the back end.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; (
  input  logic          start,
  input  logic [3:0]    func,
  input  logic [DW-1:0] a_re,
  input  logic [DW-1:0] a_im,
  input  logic [DW-1:0] b_re,
  input  logic [DW-1:0] b_im,
  input  logic          q_full,
  output logic          busy,
  output logic          push,
  output item_t         push_item
);

  assign busy = q_full;
  assign push = start & ~q_full;

  // decode
  always_comb begin
    push_item.kind = K_NONE;
    push_item.sub  = 1'b0;
    push_item.scal = 1'b0;
    push_item.a_re = a_re;
    push_item.a_im = a_im;
    push_item.b_re = b_re;
    push_item.b_im = b_im;
    unique case (func)
      FN_ADD:  push_item.kind = K_ADDSUB;
      FN_SUB:  begin
        push_item.kind = K_ADDSUB;
        push_item.sub  = 1'b1;
      end
      FN_MUL:  push_item.kind = K_MUL;
      FN_DIV:  push_item.kind = K_DIV;
      FN_SADD: begin
        push_item.kind = K_ADDSUB;
        push_item.scal = 1'b1;
      end
      FN_SSUB: begin
        push_item.kind = K_ADDSUB;
        push_item.sub  = 1'b1;
        push_item.scal = 1'b1;
      end
      FN_SMUL: begin
        push_item.kind = K_MUL;
        push_item.scal = 1'b1;
      end
      FN_SDIV: begin
        push_item.kind = K_DIV;
        push_item.scal = 1'b1;
      end
      FN_MOD:  push_item.kind = K_MOD;
      default: push_item.kind = K_NONE;
    endcase
  end

endmodule

// ===== design/cau_queue.sv =====
// ----------------------------------------------------------------------------
// cau_queue: two-entry queue between decode and execution
// Head-first register queue; entry 0 is always the head.
// ----------------------------------------------------------------------------
module cau_queue import cau_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  head_valid,
  output item_t head_item
);

  logic [1:0] cnt_r, cnt_nxt;
  item_t      q0_r, q0_nxt;
  item_t      q1_r, q1_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_item  = q0_r;

  // occupancy and entry moves
  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    if (pop) begin
      q0_nxt = q1_r;
    end
    if (push) begin
      if (cnt_r == 2'd0 || (cnt_r == 2'd1 && pop)) begin
        q0_nxt = push_item;
      end else begin
        q1_nxt = push_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

endmodule

// ===== design/cau_back.sv =====
// ----------------------------------------------------------------------------
// cau_back: execution pipeline
// Products, sums, sign split, then a bit-per-stage divider pair and square
// root, then the saturating output register. Never stalls.
// ----------------------------------------------------------------------------
module cau_back import cau_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  item_t         head_item,
  output logic          pop,
  output logic          res_valid,
  output logic [DW-1:0] res_re,
  output logic [DW-1:0] res_im,
  output logic          res_dz,
  output logic          res_sat
);

  // product stage
  logic          p_vld_r;
  item_t         p_it_r;
  logic [PW-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic [DW-1:0] m4_op, m5_op;

  // sum stage
  logic          s_vld_r;
  logic [2:0]    s_kind_r;
  logic [PW-1:0] s_wre_r, s_wim_r, s_den_r;
  logic          s_flip_r;
  logic [PW-1:0] s_wre_nxt, s_wim_nxt, s_den_nxt;
  logic          s_flip_nxt;
  logic [DW:0]   sum_re, sum_im;
  logic [DW-1:0] dd_op;
  logic [PW-1:0] c_ext;

  // sign split stage
  logic          m_vld_r;
  logic [2:0]    m_kind_r;
  sm_t           m_re_r, m_im_r;
  logic [PW-1:0] m_den_r;
  logic          m_dz_r;
  sm_t           sp_re, sp_im;

  // step pipeline
  logic          st_vld_r [0:NSTEP];
  ctl_t          st_ctl_r [0:NSTEP];
  dlane_t        st_dre_r [0:NSTEP];
  dlane_t        st_dim_r [0:NSTEP];
  sq_t           st_sq_r  [0:NSTEP];
  logic [PW-1:0] st_den_r [0:NSTEP];

  ctl_t          i_ctl;
  dlane_t        i_dre, i_dim;
  sq_t           i_sq;
  logic [PW-1:0] sh_re, sh_im;
  packed_t       pk_re, pk_im;
  logic [PW+FRAC_BITS-1:0] nf_re, nf_im;

  // output register
  logic          o_vld_r;
  logic [DW-1:0] o_re_r, o_im_r, o_re_nxt, o_im_nxt;
  logic          o_dz_r, o_sat_r, o_dz_nxt, o_sat_nxt;
  packed_t       f_re, f_im;
  logic [PW-1:0] f_mre, f_mim;

  assign pop = head_valid;

  // multipliers: the last pair squares B for divide or A for modulus
  assign m4_op = (head_item.kind == K_MOD) ? head_item.a_re : head_item.b_re;
  assign m5_op = (head_item.kind == K_MOD) ? head_item.a_im : head_item.b_im;

  always_ff @(posedge clk) begin
    p_it_r <= head_item;
    p0_r   <= PW'($signed(head_item.a_re) * $signed(head_item.b_re));
    p1_r   <= PW'($signed(head_item.a_im) * $signed(head_item.b_im));
    p2_r   <= PW'($signed(head_item.a_re) * $signed(head_item.b_im));
    p3_r   <= PW'($signed(head_item.a_im) * $signed(head_item.b_re));
    p4_r   <= PW'($signed(m4_op) * $signed(m4_op));
    p5_r   <= PW'($signed(m5_op) * $signed(m5_op));
  end

  // sums per operation class
  assign dd_op  = p_it_r.scal ? '0 : p_it_r.b_im;
  assign sum_re = p_it_r.sub ?
                  ({p_it_r.a_re[DW-1], p_it_r.a_re} - {p_it_r.b_re[DW-1], p_it_r.b_re}) :
                  ({p_it_r.a_re[DW-1], p_it_r.a_re} + {p_it_r.b_re[DW-1], p_it_r.b_re});
  assign sum_im = p_it_r.sub ?
                  ({p_it_r.a_im[DW-1], p_it_r.a_im} - {dd_op[DW-1], dd_op}) :
                  ({p_it_r.a_im[DW-1], p_it_r.a_im} + {dd_op[DW-1], dd_op});
  assign c_ext  = PW'($signed(p_it_r.b_re));

  always_comb begin
    s_wre_nxt  = '0;
    s_wim_nxt  = '0;
    s_den_nxt  = '0;
    s_flip_nxt = 1'b0;
    unique case (p_it_r.kind)
      K_ADDSUB: begin
        s_wre_nxt = PW'($signed(sum_re));
        s_wim_nxt = PW'($signed(sum_im));
      end
      K_MUL: begin
        if (p_it_r.scal) begin
          s_wre_nxt = p0_r;
          s_wim_nxt = p3_r;
        end else begin
          s_wre_nxt = p0_r - p1_r;
          s_wim_nxt = p2_r + p3_r;
        end
      end
      K_DIV: begin
        if (p_it_r.scal) begin
          s_wre_nxt  = PW'($signed(p_it_r.a_re));
          s_wim_nxt  = PW'($signed(p_it_r.a_im));
          s_flip_nxt = p_it_r.b_re[DW-1];
          s_den_nxt  = p_it_r.b_re[DW-1] ? (~c_ext + PW'(1)) : c_ext;
        end else begin
          s_wre_nxt = p0_r + p1_r;
          s_wim_nxt = p3_r - p2_r;
          s_den_nxt = p4_r + p5_r;
        end
      end
      K_MOD:   s_den_nxt = p4_r + p5_r;
      default: s_den_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    s_kind_r <= p_it_r.kind;
    s_wre_r  <= s_wre_nxt;
    s_wim_r  <= s_wim_nxt;
    s_den_r  <= s_den_nxt;
    s_flip_r <= s_flip_nxt;
  end

  // sign and magnitude of both parts, divide-by-zero detect
  always_comb begin
    sp_re     = split_wrap(s_wre_r);
    sp_im     = split_wrap(s_wim_r);
    sp_re.neg = sp_re.neg ^ s_flip_r;
    sp_im.neg = sp_im.neg ^ s_flip_r;
  end

  always_ff @(posedge clk) begin
    m_kind_r <= s_kind_r;
    m_re_r   <= sp_re;
    m_im_r   <= sp_im;
    m_den_r  <= s_den_r;
    m_dz_r   <= (s_kind_r == K_DIV) && (s_den_r == '0);
  end

  // finish simple results, set up divider and square root
  assign sh_re = (m_kind_r == K_MUL) ? (m_re_r.mag >> FRAC_BITS) : m_re_r.mag;
  assign sh_im = (m_kind_r == K_MUL) ? (m_im_r.mag >> FRAC_BITS) : m_im_r.mag;
  assign nf_re = {m_re_r.mag, {FRAC_BITS{1'b0}}};
  assign nf_im = {m_im_r.mag, {FRAC_BITS{1'b0}}};

  always_comb begin
    pk_re     = sat_pack(m_re_r.neg, sh_re);
    pk_im     = sat_pack(m_im_r.neg, sh_im);
    i_ctl.kind = m_kind_r;
    i_ctl.dz   = m_dz_r;
    i_ctl.sat  = pk_re.sat | pk_im.sat;
    i_ctl.re   = pk_re.val;
    i_ctl.im   = pk_im.val;
    i_dre.neg  = m_re_r.neg;
    i_dre.rem  = PW'(nf_re[PW+FRAC_BITS-1:QW]);
    i_dre.ovf  = (i_dre.rem >= m_den_r);
    i_dre.quo  = '0;
    i_dre.nlo  = nf_re[QW-1:0];
    i_dim.neg  = m_im_r.neg;
    i_dim.rem  = PW'(nf_im[PW+FRAC_BITS-1:QW]);
    i_dim.ovf  = (i_dim.rem >= m_den_r);
    i_dim.quo  = '0;
    i_dim.nlo  = nf_im[QW-1:0];
    i_sq.rn    = SQ_W'(m_den_r);
    i_sq.rt    = '0;
  end

  always_ff @(posedge clk) begin
    st_ctl_r[0] <= i_ctl;
    st_dre_r[0] <= i_dre;
    st_dim_r[0] <= i_dim;
    st_sq_r[0]  <= i_sq;
    st_den_r[0] <= m_den_r;
  end

  // valid line through the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r     <= 1'b0;
      s_vld_r     <= 1'b0;
      m_vld_r     <= 1'b0;
      st_vld_r[0] <= 1'b0;
    end else begin
      p_vld_r     <= head_valid;
      s_vld_r     <= p_vld_r;
      m_vld_r     <= s_vld_r;
      st_vld_r[0] <= m_vld_r;
    end
  end

  // one quotient bit per lane and one root bit per stage
  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_vld_r[k+1] <= 1'b0;
      end else begin
        st_vld_r[k+1] <= st_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      st_ctl_r[k+1] <= st_ctl_r[k];
      st_den_r[k+1] <= st_den_r[k];
      st_dre_r[k+1] <= div_step(st_dre_r[k], st_den_r[k]);
      st_dim_r[k+1] <= div_step(st_dim_r[k], st_den_r[k]);
      st_sq_r[k+1]  <= sq_step(st_sq_r[k], NSTEP - 1 - k);
    end
  end

  // final pack and result select
  assign f_mre = st_dre_r[NSTEP].ovf ? '1 : PW'(st_dre_r[NSTEP].quo);
  assign f_mim = st_dim_r[NSTEP].ovf ? '1 : PW'(st_dim_r[NSTEP].quo);

  always_comb begin
    f_re      = sat_pack(st_dre_r[NSTEP].neg, f_mre);
    f_im      = sat_pack(st_dim_r[NSTEP].neg, f_mim);
    o_re_nxt  = '0;
    o_im_nxt  = '0;
    o_sat_nxt = 1'b0;
    o_dz_nxt  = st_ctl_r[NSTEP].dz;
    unique case (st_ctl_r[NSTEP].kind)
      K_ADDSUB, K_MUL: begin
        o_re_nxt  = st_ctl_r[NSTEP].re;
        o_im_nxt  = st_ctl_r[NSTEP].im;
        o_sat_nxt = st_ctl_r[NSTEP].sat;
      end
      K_DIV: begin
        o_re_nxt  = f_re.val;
        o_im_nxt  = f_im.val;
        o_sat_nxt = f_re.sat | f_im.sat;
      end
      K_MOD: begin
        f_re      = sat_pack(1'b0, PW'(st_sq_r[NSTEP].rt));
        o_re_nxt  = f_re.val;
        o_sat_nxt = f_re.sat;
      end
      default: o_re_nxt = '0;
    endcase
    if (o_dz_nxt) begin
      o_re_nxt  = '0;
      o_im_nxt  = '0;
      o_sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else begin
      o_vld_r <= st_vld_r[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    o_re_r  <= o_re_nxt;
    o_im_r  <= o_im_nxt;
    o_dz_r  <= o_dz_nxt;
    o_sat_r <= o_sat_nxt;
  end

  assign res_valid = o_vld_r;
  assign res_re    = o_re_r;
  assign res_im    = o_im_r;
  assign res_dz    = o_dz_r;
  assign res_sat   = o_sat_r;

endmodule

// ===== design/complex_arith_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arith_unit: pipelined complex-number ALU in signed Q16.16
// Add, subtract, multiply, divide (complex or by a real scalar) and modulus
// with saturation and a divide-by-zero flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_func and the four operand ports and raise start. The
//   command transfers at a rising edge with start high and busy low. busy
//   reflects a full intake queue; the execution pipeline never stalls, so
//   in practice busy stays low and one command can transfer every cycle.
//   Output: out_valid is high for exactly one cycle per command, in command
//   order, with out_r_re, out_r_im, out_div_by_zero and out_saturated. The
//   receiver cannot stall; the result transfers at the edge ending that
//   cycle. A command passes the queue, products, sums, sign split,
//   divider/root setup, the steps that give one of 33 result bits per
//   stage, and the output register. Throughput: one command per clock cycle.
//   Reset (rst_n low, synchronous) empties the queue and drops every command
//   in flight; no result appears for them.
// ----------------------------------------------------------------------------
module complex_arith_unit import cau_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [3:0]    in_func,
  input  logic [DW-1:0] in_a_re,
  input  logic [DW-1:0] in_a_im,
  input  logic [DW-1:0] in_b_re,
  input  logic [DW-1:0] in_b_im,
  output logic          out_valid,
  output logic [DW-1:0] out_r_re,
  output logic [DW-1:0] out_r_im,
  output logic          out_div_by_zero,
  output logic          out_saturated
);

  logic  q_full;
  logic  push;
  item_t push_item;
  logic  pop;
  logic  head_valid;
  item_t head_item;

  // intake and decode
  cau_front u_front (
    .start     (start),
    .func      (in_func),
    .a_re      (in_a_re),
    .a_im      (in_a_im),
    .b_re      (in_b_re),
    .b_im      (in_b_im),
    .q_full    (q_full),
    .busy      (busy),
    .push      (push),
    .push_item (push_item)
  );

  // decoupling queue
  cau_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // execution
  cau_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .res_valid  (out_valid),
    .res_re     (out_r_re),
    .res_im     (out_r_im),
    .res_dz     (out_div_by_zero),
    .res_sat    (out_saturated)
  );

endmodule

// ===== design/cau_checker.sv =====
// ----------------------------------------------------------------------------
// cau_checker: port-level checks for complex_arith_unit
// Result timing against command transfers and flag consistency.
// ----------------------------------------------------------------------------
module cau_checker import cau_pkg::*; (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic [3:0]    in_func,
  input logic          out_valid,
  input logic [DW-1:0] out_r_re,
  input logic [DW-1:0] out_r_im,
  input logic          out_div_by_zero,
  input logic          out_saturated
);

  // every result traces back to a command transfer a fixed time earlier
  a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, CAU_LATENCY))
    else $error("result without matching command transfer");

  // the pipeline never backs up into the queue
  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("intake queue filled");

  // divide by zero returns a clean zero
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_div_by_zero) |->
      (out_r_re == '0 && out_r_im == '0 && !out_saturated))
    else $error("divide by zero with nonzero result");

  // only divide commands can flag divide by zero
  a_dz_func: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_div_by_zero) |->
      ($past(in_func, CAU_LATENCY) == FN_DIV || $past(in_func, CAU_LATENCY) == FN_SDIV))
    else $error("divide by zero flagged on non-divide command");

  // modulus has no imaginary part
  a_mod_im: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_func, CAU_LATENCY) == FN_MOD) |->
      (out_r_im == '0 && !out_div_by_zero))
    else $error("modulus result with imaginary part");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the complex arithmetic unit
// Commands go in through the start/busy port; a bit-exact Q16.16 model
// predicts each result and a monitor compares every out_valid strobe with
// the oldest pending prediction. Directed corner cases come first, then
// random traffic with idle bursts, then a back-to-back stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import cau_pkg::*;

  localparam logic [63:0] TOP64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] QCAP  = 64'h0000_0100_0000_0000;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        dz;
    logic        sat;
  } cplx_res_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [3:0]    in_func = FN_ADD;
  logic [DW-1:0] in_a_re = '0;
  logic [DW-1:0] in_a_im = '0;
  logic [DW-1:0] in_b_re = '0;
  logic [DW-1:0] in_b_im = '0;
  logic          out_valid;
  logic [DW-1:0] out_r_re;
  logic [DW-1:0] out_r_im;
  logic          out_div_by_zero;
  logic          out_saturated;

  cplx_res_t pending_q[$];
  int        n_err = 0;

  complex_arith_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_a_re(in_a_re), .in_a_im(in_a_im),
    .in_b_re(in_b_re), .in_b_im(in_b_im),
    .out_valid(out_valid), .out_r_re(out_r_re), .out_r_im(out_r_im),
    .out_div_by_zero(out_div_by_zero), .out_saturated(out_saturated)
  );

  always #2 clk = ~clk;

  // sign and magnitude into {clipped, 32-bit field}
  function automatic logic [32:0] clip32(input logic neg, input logic [63:0] mag);
    if (neg) begin
      if (mag > 64'h8000_0000) return {1'b1, 32'h8000_0000};
      return {1'b0, 32'(~mag + 64'd1)};
    end
    if (mag > 64'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
    return {1'b0, mag[31:0]};
  endfunction

  // wrapped 64-bit sum whose true value lies in (-2^63, 2^63]
  function automatic logic [64:0] wrap_sm(input logic [63:0] u);
    if (u == TOP64) return {1'b0, u};
    return {u[63], u[63] ? (~u + 64'd1) : u};
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // (mag << FRAC_BITS) / den, truncated and capped
  function automatic logic [63:0] qdiv(input logic [63:0] mag, input logic [63:0] den);
    logic [127:0] q;
    q = ({64'd0, mag} << FRAC_BITS) / {64'd0, den};
    return (q > {64'd0, QCAP}) ? QCAP : q[63:0];
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t <= {64'd0, n}) r = t;
    end
    return r[63:0];
  endfunction

  function automatic cplx_res_t alu_result(input logic [3:0] f, input logic [31:0] ar,
                                           input logic [31:0] ai, input logic [31:0] br,
                                           input logic [31:0] bi);
    cplx_res_t        r;
    logic signed [63:0] a, b, c, d, s;
    logic [63:0]      den;
    logic [64:0]      sm;
    logic [32:0]      p;
    logic             cn;
    a = {{32{ar[31]}}, ar};
    b = {{32{ai[31]}}, ai};
    c = {{32{br[31]}}, br};
    d = {{32{bi[31]}}, bi};
    r = '0;
    cn = c < 0;
    case (f)
      FN_ADD, FN_SUB, FN_SADD, FN_SSUB: begin
        s = (f == FN_SUB || f == FN_SSUB) ? a - c : a + c;
        p = clip32(s < 0, abs64(s));
        r.re = p[31:0]; r.sat |= p[32];
        if (f == FN_SADD || f == FN_SSUB) s = b;
        else s = (f == FN_SUB) ? b - d : b + d;
        p = clip32(s < 0, abs64(s));
        r.im = p[31:0]; r.sat |= p[32];
      end
      FN_MUL, FN_SMUL: begin
        sm = wrap_sm((f == FN_MUL) ? 64'(a * c) - 64'(b * d) : 64'(a * c));
        p = clip32(sm[64], sm[63:0] >> FRAC_BITS);
        r.re = p[31:0]; r.sat |= p[32];
        sm = wrap_sm((f == FN_MUL) ? 64'(a * d) + 64'(b * c) : 64'(b * c));
        p = clip32(sm[64], sm[63:0] >> FRAC_BITS);
        r.im = p[31:0]; r.sat |= p[32];
      end
      FN_DIV: begin
        den = 64'(c * c) + 64'(d * d);
        if (den == 0) r.dz = 1'b1;
        else begin
          sm = wrap_sm(64'(a * c) + 64'(b * d));
          p = clip32(sm[64], qdiv(sm[63:0], den));
          r.re = p[31:0]; r.sat |= p[32];
          sm = wrap_sm(64'(b * c) - 64'(a * d));
          p = clip32(sm[64], qdiv(sm[63:0], den));
          r.im = p[31:0]; r.sat |= p[32];
        end
      end
      FN_SDIV: begin
        if (c == 0) r.dz = 1'b1;
        else begin
          p = clip32((a < 0) != cn, qdiv(abs64(a), abs64(c)));
          r.re = p[31:0]; r.sat |= p[32];
          p = clip32((b < 0) != cn, qdiv(abs64(b), abs64(c)));
          r.im = p[31:0]; r.sat |= p[32];
        end
      end
      FN_MOD: begin
        p = clip32(1'b0, floor_sqrt(64'(a * a) + 64'(b * b)));
        r.re = p[31:0]; r.sat |= p[32];
      end
      default: ;
    endcase
    return r;
  endfunction

  // drive one command and hold it until it transfers
  task automatic issue_cmd(input logic [3:0] f, input logic [31:0] ar, input logic [31:0] ai,
                           input logic [31:0] br, input logic [31:0] bi);
    start   <= 1'b1;
    in_func <= f;
    in_a_re <= ar;
    in_a_im <= ai;
    in_b_re <= br;
    in_b_im <= bi;
    do @(posedge clk); while (busy);
    pending_q.push_back(alu_result(f, ar, ai, br, bi));
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // operand value biased toward corners and small Q16.16 numbers
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(0, 8)) - 4) << FRAC_BITS;
      3: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      4: return '0;
      default: return $urandom;
    endcase
  endfunction

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result re=%h im=%h dz=%b sat=%b", $time,
                 out_r_re, out_r_im, out_div_by_zero, out_saturated);
        n_err++;
      end else begin
        cplx_res_t e;
        e = pending_q.pop_front();
        if (e.re !== out_r_re) begin
          $display("%0t: r_re expected %h actual %h", $time, e.re, out_r_re);
          n_err++;
        end
        if (e.im !== out_r_im) begin
          $display("%0t: r_im expected %h actual %h", $time, e.im, out_r_im);
          n_err++;
        end
        if (e.dz !== out_div_by_zero) begin
          $display("%0t: div_by_zero expected %b actual %b", $time, e.dz, out_div_by_zero);
          n_err++;
        end
        if (e.sat !== out_saturated) begin
          $display("%0t: saturated expected %b actual %b", $time, e.sat, out_saturated);
          n_err++;
        end
      end
    end
  end

  task automatic test_corners();
    issue_cmd(FN_ADD,  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    issue_cmd(FN_SUB,  32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    issue_cmd(FN_ADD,  32'h0001_8000, 32'hFFFF_0000, 32'h0000_8000, 32'h0002_0000);
    issue_cmd(FN_MUL,  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    issue_cmd(FN_MUL,  32'h0002_0000, 32'h0003_0000, 32'hFFFF_8000, 32'h0001_0000);
    issue_cmd(FN_DIV,  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    issue_cmd(FN_DIV,  32'h0005_0000, 32'hFFFE_0000, 32'h0001_0000, 32'h0002_0000);
    issue_cmd(FN_DIV,  32'h1234_5678, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
    issue_cmd(FN_DIV,  32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
    issue_cmd(FN_SADD, 32'h7FFF_FFFF, 32'h1111_1111, 32'h0000_0001, 32'h7FFF_FFFF);
    issue_cmd(FN_SSUB, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000);
    issue_cmd(FN_SMUL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0005);
    issue_cmd(FN_SMUL, 32'h0003_0000, 32'hFFFF_0000, 32'hFFFE_0000, 32'hFFFF_FFFF);
    issue_cmd(FN_SDIV, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0001_0000);
    issue_cmd(FN_SDIV, 32'h0000_0000, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    issue_cmd(FN_SDIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFE_0000, 32'h0000_0000);
    issue_cmd(FN_MOD,  32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    issue_cmd(FN_MOD,  32'h0003_0000, 32'hFFFC_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_cmd(4'd9,    32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    issue_cmd(4'd15,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // random commands, mostly valid codes, with optional idle bursts
  task automatic test_random(input int n, input bit gaps);
    logic [3:0] f;
    for (int i = 0; i < n; i++) begin
      f = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      issue_cmd(f, pick_operand(), pick_operand(), pick_operand(), pick_operand());
      if (gaps && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 8));
    end
    start <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corners();
    test_random(330, 1'b1);
    test_random(100, 1'b0);
    // drain
    for (int k = 0; k < 10000 && pending_q.size() != 0; k++) @(posedge clk);
    repeat (CAU_LATENCY + 8) @(posedge clk);
    if (n_err == 0 && pending_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
